[rtl/display_power_touch_controller_macros.svh]
// assertion macros for the display power and touch controller
// expects clk and arst_n in the scope where a macro is used
`ifndef DISPLAY_POWER_TOUCH_CONTROLLER_MACROS_SVH
`define DISPLAY_POWER_TOUCH_CONTROLLER_MACROS_SVH

// same-cycle implication, disabled during reset
`define DPTC_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dptc assertion failed");

// next-cycle implication, disabled during reset
`define DPTC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dptc assertion failed");

`endif

[rtl/dptc_pkg.sv]
// shared types and codes for the display power and touch controller
// no dependencies
`timescale 1ns / 1ps

package dptc_pkg;

	// event codes after classification
	localparam logic [3:0] OP_TICK        = 4'd0;
	localparam logic [3:0] OP_PRESS       = 4'd1;
	localparam logic [3:0] OP_LONG_PRESS  = 4'd2;
	localparam logic [3:0] OP_CLICK       = 4'd3;
	localparam logic [3:0] OP_RELEASE     = 4'd4;
	localparam logic [3:0] OP_SLIDER      = 4'd5;
	localparam logic [3:0] OP_SLIDER_DONE = 4'd6;
	localparam logic [3:0] OP_NEXT_PROF   = 4'd7;
	localparam logic [3:0] OP_CLOSE       = 4'd8;
	localparam logic [3:0] OP_NOP         = 4'd9;

	// display modes
	localparam logic [1:0] MODE_ACTIVE = 2'd0;
	localparam logic [1:0] MODE_DIMMED = 2'd1;
	localparam logic [1:0] MODE_OFF    = 2'd2;

	// save request codes
	localparam logic [1:0] SAVE_NONE    = 2'd0;
	localparam logic [1:0] SAVE_LEVEL   = 2'd1;
	localparam logic [1:0] SAVE_PROFILE = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_FAST_DIM = 3'd0;
	localparam logic [2:0] REG_FAST_OFF = 3'd1;
	localparam logic [2:0] REG_SLOW_DIM = 3'd2;
	localparam logic [2:0] REG_SLOW_OFF = 3'd3;
	localparam logic [2:0] REG_DIM_CAP  = 3'd4;

	// slider limits
	localparam logic [6:0] LEVEL_MIN = 7'd10;
	localparam logic [6:0] LEVEL_MAX = 7'd100;

	// classified event as held in the queue
	typedef struct packed {
		logic [3:0]  op;
		logic [31:0] now_ms;
		logic [6:0]  level;
	} cmd_t;

	// queue occupancy flags
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

[rtl/dptc_front.sv]
// front end: takes input transfers, classifies opcodes, saturates the slider level
// depends on dptc_pkg
`timescale 1ns / 1ps

module dptc_front import dptc_pkg::*; (
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  opcode,
	input  logic [31:0] now_ms,
	input  logic [6:0]  slider_level,
	input  q_status_t   q_status,
	output logic        push,
	output cmd_t        push_cmd
);

	// accept whenever the queue has room
	assign in_stall = q_status.full;
	assign push     = in_valid && !q_status.full;

	// classification and level clamp
	always_comb begin
		push_cmd.now_ms = now_ms;
		if (opcode inside {[OP_TICK:OP_CLOSE]}) begin
			push_cmd.op = opcode;
		end else begin
			push_cmd.op = OP_NOP;
		end
		if (slider_level < LEVEL_MIN) begin
			push_cmd.level = LEVEL_MIN;
		end else if (slider_level > LEVEL_MAX) begin
			push_cmd.level = LEVEL_MAX;
		end else begin
			push_cmd.level = slider_level;
		end
	end

endmodule

[rtl/dptc_queue.sv]
// short command queue between front and back
// depends on dptc_pkg
`timescale 1ns / 1ps

module dptc_queue import dptc_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cmd_t      push_cmd,
	input  logic      pop,
	output cmd_t      head_cmd,
	output q_status_t q_status
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign q_status.full  = (count_q == CW'(DEPTH));
	assign q_status.empty = (count_q == '0);
	assign head_cmd       = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/dptc_back.sv]
// back end: power state, configuration registers and the output register
// depends on dptc_pkg
`timescale 1ns / 1ps

module dptc_back import dptc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  q_status_t   q_status,
	input  cmd_t        head_cmd,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  backlight_level,
	output logic        backlight_write,
	output logic [1:0]  display_mode,
	output logic        redraw_running,
	output logic        repaint_now,
	output logic        settings_shown,
	output logic [1:0]  save_request,
	output logic [6:0]  saved_value,
	output logic [1:0]  profile_now
);

	// working copy of the state plus the per-event strobes
	typedef struct packed {
		logic [1:0]  mode;
		logic [6:0]  drv;
		logic [6:0]  chosen;
		logic [1:0]  prof;
		logic [31:0] last;
		logic        wake;
		logic        lng;
		logic        cont;
		logic        pan;
		logic        anim;
		logic        wr;
		logic        rep;
	} st_t;

	logic [31:0] fast_dim_q, fast_off_q, slow_dim_q, slow_off_q;
	logic [6:0]  dim_cap_q;

	st_t         cur_q;
	st_t         nx;
	logic [1:0]  save;
	logic [6:0]  saved;
	logic [31:0] elapsed;
	logic [31:0] dim_lim;
	logic [31:0] off_lim;
	logic        out_valid_q;

	function automatic st_t drive_f(st_t s, logic [6:0] lvl);
		st_t r;
		r = s;
		if (lvl != r.drv) begin
			r.drv = lvl;
			r.wr  = 1'b1;
		end
		return r;
	endfunction

	function automatic st_t enter_f(st_t s, logic [1:0] m, logic [6:0] cap);
		st_t r;
		r = s;
		if (m != r.mode) begin
			r.mode = m;
			case (m)
				MODE_ACTIVE: begin
					r      = drive_f(r, r.chosen);
					r.anim = 1'b1;
					r.rep  = 1'b1;
				end
				MODE_DIMMED: begin
					r      = drive_f(r, (r.chosen < cap) ? r.chosen : cap);
					r.anim = 1'b1;
				end
				default: begin
					r      = drive_f(r, 7'd0);
					r.anim = 1'b0;
				end
			endcase
		end
		return r;
	endfunction

	// take the next command when the output register is free or draining
	assign pop = !q_status.empty && (!out_valid_q || !out_stall);

	// timeout limits of the current profile
	assign elapsed = head_cmd.now_ms - cur_q.last;
	assign dim_lim = (cur_q.prof == 2'd0) ? fast_dim_q : slow_dim_q;
	assign off_lim = (cur_q.prof == 2'd0) ? fast_off_q : slow_off_q;

	// event execution
	always_comb begin
		nx     = cur_q;
		nx.wr  = 1'b0;
		nx.rep = 1'b0;
		save   = SAVE_NONE;
		saved  = 7'd0;
		case (head_cmd.op)
			OP_TICK: begin
				if (!cur_q.pan && cur_q.prof < 2'd2) begin
					if (elapsed >= off_lim) begin
						nx = enter_f(nx, MODE_OFF, dim_cap_q);
					end else if (elapsed >= dim_lim) begin
						nx = enter_f(nx, MODE_DIMMED, dim_cap_q);
					end
				end
			end
			OP_PRESS: begin
				if (!cur_q.cont) begin
					nx.cont = 1'b1;
					nx.wake = (cur_q.mode != MODE_ACTIVE);
					nx.lng  = 1'b0;
					if (cur_q.mode != MODE_ACTIVE) begin
						nx.last = head_cmd.now_ms;
						nx      = enter_f(nx, MODE_ACTIVE, dim_cap_q);
					end
				end
			end
			OP_LONG_PRESS: begin
				if (!cur_q.wake) begin
					nx.lng = 1'b1;
					if (!cur_q.pan) begin
						nx.pan  = 1'b1;
						nx.last = head_cmd.now_ms;
						nx      = enter_f(nx, MODE_ACTIVE, dim_cap_q);
					end
				end
			end
			OP_CLICK: begin
				nx.last = head_cmd.now_ms;
				nx      = enter_f(nx, MODE_ACTIVE, dim_cap_q);
				if (!cur_q.wake && !cur_q.lng && !cur_q.pan) begin
					// brightness steps 40, 70, 100 and back to 40
					if (cur_q.chosen < 7'd40) begin
						nx.chosen = 7'd40;
					end else if (cur_q.chosen < 7'd70) begin
						nx.chosen = 7'd70;
					end else if (cur_q.chosen < 7'd100) begin
						nx.chosen = 7'd100;
					end else begin
						nx.chosen = 7'd40;
					end
					nx    = drive_f(nx, nx.chosen);
					save  = SAVE_LEVEL;
					saved = nx.chosen;
				end
				nx.wake = 1'b0;
				nx.lng  = 1'b0;
			end
			OP_RELEASE: begin
				nx.cont = 1'b0;
			end
			OP_SLIDER: begin
				if (cur_q.pan) begin
					nx.chosen = head_cmd.level;
					nx.mode   = MODE_ACTIVE;
					nx        = drive_f(nx, head_cmd.level);
					nx.last   = head_cmd.now_ms;
				end
			end
			OP_SLIDER_DONE: begin
				if (cur_q.pan) begin
					save  = SAVE_LEVEL;
					saved = cur_q.chosen;
				end
			end
			OP_NEXT_PROF: begin
				if (cur_q.pan) begin
					nx.prof = (cur_q.prof >= 2'd2) ? 2'd0 : cur_q.prof + 2'd1;
					save    = SAVE_PROFILE;
					saved   = {5'd0, nx.prof};
					nx.last = head_cmd.now_ms;
				end
			end
			OP_CLOSE: begin
				if (cur_q.pan) begin
					nx.pan  = 1'b0;
					nx.last = head_cmd.now_ms;
					nx      = enter_f(nx, MODE_ACTIVE, dim_cap_q);
				end
			end
			default: begin
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_dim_q <= 32'd15000;
			fast_off_q <= 32'd45000;
			slow_dim_q <= 32'd30000;
			slow_off_q <= 32'd120000;
			dim_cap_q  <= 7'd12;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FAST_DIM: fast_dim_q <= cfg_data;
				REG_FAST_OFF: fast_off_q <= cfg_data;
				REG_SLOW_DIM: slow_dim_q <= cfg_data;
				REG_SLOW_OFF: slow_off_q <= cfg_data;
				REG_DIM_CAP:  dim_cap_q  <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	// power state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '{mode: MODE_ACTIVE, drv: 7'd70, chosen: 7'd70, prof: 2'd0,
				last: 32'd0, wake: 1'b0, lng: 1'b0, cont: 1'b0, pan: 1'b0,
				anim: 1'b1, wr: 1'b0, rep: 1'b0};
		end else if (pop) begin
			cur_q <= nx;
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			backlight_level <= nx.drv;
			backlight_write <= nx.wr;
			display_mode    <= nx.mode;
			redraw_running  <= nx.anim;
			repaint_now     <= nx.rep;
			settings_shown  <= nx.pan;
			save_request    <= save;
			saved_value     <= saved;
			profile_now     <= nx.prof;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[rtl/display_power_touch_controller.sv]
// top level of the display power and touch controller
// depends on dptc_pkg, dptc_front, dptc_queue, dptc_back and the macros header
//
// channel   direction  handshake            payload
// in        sink       in_valid / in_stall  opcode, now_ms, slider_level
// out       source     out_valid / out_stall  backlight_level .. profile_now
// cfg       sink       cfg_write            cfg_index, cfg_data
//
// one event per cycle while not stalled; results pass the queue and then the output register
// the queue pops and the back end runs one command per cycle in a single step, unless stalled
// reset empties the queue, clears out_valid and loads the power state and config defaults
// a stalled output holds the back end; the front keeps taking transfers until the queue fills
`timescale 1ns / 1ps
`include "display_power_touch_controller_macros.svh"

module display_power_touch_controller import dptc_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  opcode,
	input  logic [31:0] now_ms,
	input  logic [6:0]  slider_level,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  backlight_level,
	output logic        backlight_write,
	output logic [1:0]  display_mode,
	output logic        redraw_running,
	output logic        repaint_now,
	output logic        settings_shown,
	output logic [1:0]  save_request,
	output logic [6:0]  saved_value,
	output logic [1:0]  profile_now
);

	logic      push;
	logic      pop;
	cmd_t      push_cmd;
	cmd_t      head_cmd;
	q_status_t q_status;

	// classify and push
	dptc_front u_front (
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.now_ms       (now_ms),
		.slider_level (slider_level),
		.q_status     (q_status),
		.push         (push),
		.push_cmd     (push_cmd)
	);

	// decoupling queue
	dptc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.q_status (q_status)
	);

	// execute and present results
	dptc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.q_status        (q_status),
		.head_cmd        (head_cmd),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.backlight_level (backlight_level),
		.backlight_write (backlight_write),
		.display_mode    (display_mode),
		.redraw_running  (redraw_running),
		.repaint_now     (repaint_now),
		.settings_shown  (settings_shown),
		.save_request    (save_request),
		.saved_value     (saved_value),
		.profile_now     (profile_now)
	);

	// off means dark and no redraw
	`DPTC_ASSERT_IMPLY(a_off_dark, out_valid && display_mode == MODE_OFF, backlight_level == 7'd0 && !redraw_running)
	// a repaint only comes with active mode
	`DPTC_ASSERT_IMPLY(a_repaint_active, out_valid && repaint_now, display_mode == MODE_ACTIVE)
	// no stored value without a save request
	`DPTC_ASSERT_IMPLY(a_save_value, out_valid && save_request == SAVE_NONE, saved_value == 7'd0)
	// a push into an empty queue leaves it occupied
	`DPTC_ASSERT_NEXT(a_push_fills, push && q_status.empty, !q_status.empty)

endmodule
